### hdl/escc_pkg.sv
// ----------------------------------------------------------------------------
// escc_pkg
// Shared constants and calendar helpers for the epoch/calendar converter.
// ----------------------------------------------------------------------------
package escc_pkg;

    localparam int unsigned PIPE_DEPTH = 7;

    localparam logic [11:0] EPOCH_YEAR = 12'd1970;
    localparam logic [11:0] LAST_YEAR  = 12'd2099;

    // floor(x / c) = (x * RECIP) >> SHIFT over the operand ranges used here
    localparam logic [25:0] DAY_RECIP  = 26'd50903317; // x / 675, x < 2^25
    localparam int unsigned DAY_SHIFT  = 35;
    localparam logic [15:0] YEAR_RECIP = 16'd45965;    // x / 365, x < 2^16
    localparam int unsigned YEAR_SHIFT = 24;
    localparam logic [17:0] HOUR_RECIP = 18'd149131;   // x / 3600, x < 86400
    localparam int unsigned HOUR_SHIFT = 29;
    localparam logic [12:0] MIN_RECIP  = 13'd4370;     // x / 60, x < 3600
    localparam int unsigned MIN_SHIFT  = 18;

    localparam logic [16:0] DAY_SECS  = 17'd86400;
    localparam logic [11:0] HOUR_SECS = 12'd3600;
    localparam logic [7:0]  IDX_2100  = 8'd130;

    typedef logic [8:0] month_tab_t [0:12];
    localparam month_tab_t MONTH_START = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    // year index counts from 1970
    function automatic logic is_leap(input logic [7:0] idx);
        return (idx[1:0] == 2'd2) && (idx != IDX_2100);
    endfunction

    // days from 1970-01-01 to Jan 1 of year 1970+idx
    function automatic logic [15:0] year_start(input logic [7:0] idx);
        logic [15:0] base;
        logic [8:0]  nxt;
        base = 16'(idx) * 16'd365;
        nxt  = {1'b0, idx} + 9'd1;
        return base + 16'(nxt[8:2]) - ((idx > IDX_2100) ? 16'd1 : 16'd0);
    endfunction

    // days of the year before month m (0-based, 0..12)
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] v;
        v = (m > 4'd12) ? MONTH_START[12] : MONTH_START[m];
        return v + ((leap && m >= 4'd2) ? 9'd1 : 9'd0);
    endfunction

endpackage

### hdl/escc_to_cal.sv
// ----------------------------------------------------------------------------
// escc_to_cal
// Seven-stage datapath: epoch seconds to year, month, day and time of day.
// ----------------------------------------------------------------------------
module escc_to_cal (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] seconds_in,
    output logic [11:0] out_year,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic [4:0]  out_hour,
    output logic [5:0]  out_minute,
    output logic [5:0]  out_second
);
    import escc_pkg::*;

    logic [31:0] s1_sec_reg;
    logic [50:0] s1_q_reg;
    logic [15:0] s2_days_reg;
    logic [31:0] s2_sec_reg;
    logic [15:0] s3_days_reg;
    logic [16:0] s3_tod_reg;
    logic [31:0] s3_cprod_reg;
    logic [15:0] s4_days_reg;
    logic [16:0] s4_tod_reg;
    logic [7:0]  s4_c_reg;
    logic [15:0] s4_st_hi_reg;
    logic [15:0] s4_st_lo_reg;
    logic [34:0] s4_hprod_reg;
    logic [7:0]  s5_idx_reg;
    logic [8:0]  s5_doy_reg;
    logic [4:0]  s5_hour_reg;
    logic [11:0] s5_rem_reg;
    logic [11:0] s6_year_reg;
    logic [3:0]  s6_month_reg;
    logic [4:0]  s6_day_reg;
    logic [4:0]  s6_hour_reg;
    logic [11:0] s6_rem_reg;
    logic [24:0] s6_mprod_reg;
    logic [11:0] s7_year_reg;
    logic [3:0]  s7_month_reg;
    logic [4:0]  s7_day_reg;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_min_reg;
    logic [5:0]  s7_sec_reg;

    logic [48:0] dprod;
    logic [16:0] tod_next;
    logic [7:0]  c_val;
    logic        use_lo;
    logic [15:0] st_sel;
    logic [15:0] doy_full;
    logic [4:0]  hour_val;
    logic [16:0] hsecs;
    logic [16:0] rem_full;
    logic        leap6;
    logic [3:0]  mcnt;
    logic [8:0]  mstart;
    logic [8:0]  dom;
    logic [5:0]  min_val;
    logic [11:0] msecs;
    logic [11:0] sec_full;

    always_comb begin
        dprod    = 49'(s2_days_reg) * 49'(DAY_SECS);
        tod_next = s2_sec_reg[16:0] - dprod[16:0];
        c_val    = s3_cprod_reg[31:24];
        use_lo   = (s4_c_reg != 8'd0) && (s4_days_reg < s4_st_hi_reg);
        st_sel   = use_lo ? s4_st_lo_reg : s4_st_hi_reg;
        doy_full = s4_days_reg - st_sel;
        hour_val = s4_hprod_reg[33:29];
        hsecs    = 17'(hour_val) * 17'(HOUR_SECS);
        rem_full = s4_tod_reg - hsecs;
        leap6    = is_leap(s5_idx_reg);
        mcnt     = '0;
        for (int k = 1; k < 12; k++) begin
            if (s5_doy_reg >= month_start(4'(k), leap6)) mcnt = 4'(k);
        end
        mstart   = month_start(mcnt, leap6);
        dom      = s5_doy_reg - mstart + 9'd1;
        min_val  = s6_mprod_reg[23:18];
        msecs    = 12'(min_val) * 12'd60;
        sec_full = s6_rem_reg - msecs;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_sec_reg   <= seconds_in;
            s1_q_reg     <= 51'(seconds_in[31:7]) * 51'(DAY_RECIP);

            s2_sec_reg   <= s1_sec_reg;
            s2_days_reg  <= s1_q_reg[50:35];

            s3_days_reg  <= s2_days_reg;
            s3_tod_reg   <= tod_next;
            s3_cprod_reg <= 32'(s2_days_reg) * 32'(YEAR_RECIP);

            s4_days_reg  <= s3_days_reg;
            s4_tod_reg   <= s3_tod_reg;
            s4_c_reg     <= c_val;
            s4_st_hi_reg <= year_start(c_val);
            s4_st_lo_reg <= year_start(c_val - 8'd1);
            s4_hprod_reg <= 35'(s3_tod_reg) * 35'(HOUR_RECIP);

            s5_idx_reg   <= use_lo ? s4_c_reg - 8'd1 : s4_c_reg;
            s5_doy_reg   <= doy_full[8:0];
            s5_hour_reg  <= hour_val;
            s5_rem_reg   <= rem_full[11:0];

            s6_year_reg  <= EPOCH_YEAR + 12'(s5_idx_reg);
            s6_month_reg <= mcnt + 4'd1;
            s6_day_reg   <= dom[4:0];
            s6_hour_reg  <= s5_hour_reg;
            s6_rem_reg   <= s5_rem_reg;
            s6_mprod_reg <= 25'(s5_rem_reg) * 25'(MIN_RECIP);

            s7_year_reg  <= s6_year_reg;
            s7_month_reg <= s6_month_reg;
            s7_day_reg   <= s6_day_reg;
            s7_hour_reg  <= s6_hour_reg;
            s7_min_reg   <= min_val;
            s7_sec_reg   <= sec_full[5:0];
        end
    end

    assign out_year   = s7_year_reg;
    assign out_month  = s7_month_reg;
    assign out_day    = s7_day_reg;
    assign out_hour   = s7_hour_reg;
    assign out_minute = s7_min_reg;
    assign out_second = s7_sec_reg;

endmodule

### hdl/escc_to_sec.sv
// ----------------------------------------------------------------------------
// escc_to_sec
// Calendar date and time to epoch seconds, matched to the seven-stage pipe.
// ----------------------------------------------------------------------------
module escc_to_sec (
    input  logic        aclk,
    input  logic        en,
    input  logic [11:0] in_year,
    input  logic [3:0]  in_month,
    input  logic [4:0]  in_day,
    input  logic [4:0]  in_hour,
    input  logic [5:0]  in_minute,
    input  logic [5:0]  in_second,
    output logic [31:0] seconds_out,
    output logic        year_out_of_range
);
    import escc_pkg::*;

    localparam int unsigned TAIL = PIPE_DEPTH - 3;

    logic        s1_oor_reg;
    logic [31:0] s1_days_reg;
    logic [16:0] s1_tp_reg;
    logic        s2_oor_reg;
    logic [31:0] s2_prod_reg;
    logic [16:0] s2_tp_reg;
    logic [31:0] acc_reg [0:TAIL];
    logic        oor_reg [0:TAIL];

    logic        oor;
    logic [7:0]  idx;
    logic [3:0]  mcount;
    logic [31:0] days;
    logic [16:0] tp;

    always_comb begin
        oor    = (in_year < EPOCH_YEAR) || (in_year > LAST_YEAR);
        idx    = 8'(in_year - EPOCH_YEAR);
        mcount = (in_month == 4'd0) ? 4'd0 : in_month - 4'd1;
        days   = 32'(year_start(idx)) + 32'(month_start(mcount, is_leap(idx)))
               + 32'(in_day) - 32'd1;
        tp     = 17'(in_hour) * 17'(HOUR_SECS) + 17'(in_minute) * 17'd60
               + 17'(in_second);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_oor_reg  <= oor;
            s1_days_reg <= days;
            s1_tp_reg   <= tp;
            s2_oor_reg  <= s1_oor_reg;
            s2_prod_reg <= s1_days_reg * 32'(DAY_SECS);
            s2_tp_reg   <= s1_tp_reg;
            acc_reg[0]  <= s2_oor_reg ? 32'd1 : s2_prod_reg + 32'(s2_tp_reg);
            oor_reg[0]  <= s2_oor_reg;
            for (int k = 1; k <= TAIL; k++) begin
                acc_reg[k] <= acc_reg[k-1];
                oor_reg[k] <= oor_reg[k-1];
            end
        end
    end

    assign seconds_out       = acc_reg[TAIL];
    assign year_out_of_range = oor_reg[TAIL];

endmodule

### hdl/epoch_seconds_calendar_convert.sv
// ----------------------------------------------------------------------------
// epoch_seconds_calendar_convert
// Both directions move through the same stage valid bits, so result beats keep input order.
// Throughput: one beat per cycle; the whole pipe holds while m_tready is low
// and the last stage is full.
// Reset: aresetn (synchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
module epoch_seconds_calendar_convert (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // seconds_in[31:0], in_year[43:32], in_month[47:44], in_day[52:48],
    // in_hour[57:53], in_minute[63:58], in_second[69:64]
    input  logic [71:0] s_tdata,
    // operation[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_year[11:0], out_month[15:12], out_day[20:16], out_hour[25:21],
    // out_minute[31:26], out_second[37:32], seconds_out[69:38],
    // year_out_of_range[70]
    output logic [71:0] m_tdata
);
    import escc_pkg::*;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] op_reg;
    logic                  en;

    logic [11:0] c_year;
    logic [3:0]  c_month;
    logic [4:0]  c_day;
    logic [4:0]  c_hour;
    logic [5:0]  c_minute;
    logic [5:0]  c_second;
    logic [31:0] t_seconds;
    logic        t_oor;
    logic        op_last;

    assign en       = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];
    assign op_last  = op_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg <= {op_reg[PIPE_DEPTH-2:0], s_tuser};
        end
    end

    escc_to_cal u_to_cal (
        .aclk       (aclk),
        .en         (en),
        .seconds_in (s_tdata[31:0]),
        .out_year   (c_year),
        .out_month  (c_month),
        .out_day    (c_day),
        .out_hour   (c_hour),
        .out_minute (c_minute),
        .out_second (c_second)
    );

    escc_to_sec u_to_sec (
        .aclk              (aclk),
        .en                (en),
        .in_year           (s_tdata[43:32]),
        .in_month          (s_tdata[47:44]),
        .in_day            (s_tdata[52:48]),
        .in_hour           (s_tdata[57:53]),
        .in_minute         (s_tdata[63:58]),
        .in_second         (s_tdata[69:64]),
        .seconds_out       (t_seconds),
        .year_out_of_range (t_oor)
    );

    always_comb begin
        m_tdata = '0;
        if (op_last) begin
            m_tdata[69:38] = t_seconds;
            m_tdata[70]    = t_oor;
        end else begin
            m_tdata[11:0]  = c_year;
            m_tdata[15:12] = c_month;
            m_tdata[20:16] = c_day;
            m_tdata[25:21] = c_hour;
            m_tdata[31:26] = c_minute;
            m_tdata[37:32] = c_second;
        end
    end

endmodule
